// ===== rtl/sfau_pkg.sv =====
package sfau_pkg;

    localparam int EXP_W = 16;
    localparam int OUT_MANT_W = 48;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4
    } op_t;

    localparam logic signed [EXP_W-1:0] EXP_ERR = 16'sh8000;
    localparam int EXP_LIM = 32767;
    localparam int EXP_FLOOR = 16383;

    // Sequencer state, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ALIGN = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_NORM  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

endpackage

// ===== rtl/sfau_core.sv =====
module sfau_core #(
    parameter int MANT_W = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [2:0]                          req_type,
    input  logic signed [sfau_pkg::EXP_W-1:0]   a_exp,
    input  logic signed [MANT_W-1:0]            a_mant,
    input  logic signed [sfau_pkg::EXP_W-1:0]   b_exp,
    input  logic signed [MANT_W-1:0]            b_mant,
    output logic                                busy,
    output logic                                done,
    output logic signed [sfau_pkg::EXP_W-1:0]   r_exp,
    output logic signed [MANT_W-1:0]            r_mant,
    output logic                                r_err
);
    import sfau_pkg::*;

    localparam int FRAC = MANT_W - 2;
    localparam int CNT_W = $clog2(2 * MANT_W + 1);
    localparam int DIFF_W = EXP_W + 2;
    localparam logic signed [MANT_W-1:0] M_ERR = {1'b1, {(MANT_W-1){1'b0}}};
    localparam logic [MANT_W-1:0] M_MAX = {1'b0, {(MANT_W-1){1'b1}}};
    localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(MANT_W);
    localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(MANT_W + FRAC);

    state_t state_reg, state_next;

    logic signed [EXP_W+1:0]   e_reg, e_next;        // working exponent
    logic                      neg_reg, neg_next;    // result sign
    logic [MANT_W:0]           v_reg, v_next;        // magnitude (one spare bit)
    logic [MANT_W-1:0]         x_reg, x_next;        // multiplicand / dividend
    logic [MANT_W-1:0]         y_reg, y_next;        // multiplier / divisor
    logic [2*MANT_W-1:0]       acc_reg, acc_next;    // product or remainder
    logic                      over_reg, over_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [EXP_W-1:0]   re_reg, re_next;
    logic signed [MANT_W-1:0]  rm_reg, rm_next;
    logic                      rerr_reg, rerr_next;
    logic                      zpass_reg, zpass_next; // normalize bypass
    logic signed [MANT_W-1:0]  am_reg, am_next, bm_reg, bm_next;
    logic signed [EXP_W-1:0]   ae_reg, ae_next, be_reg, be_next;

    // Subtractor used for division steps
    logic [MANT_W:0]           rem_sh;
    logic [MANT_W+1:0]         sub_res;
    logic                      sub_ok;
    logic [CNT_W-1:0]          bit_pos;
    logic [CNT_W-1:0]          x_idx;
    logic                      div_bit;

    function automatic logic [MANT_W-1:0] mag(input logic signed [MANT_W-1:0] m);
        mag = m[MANT_W-1] ? MANT_W'(-m) : MANT_W'(m);
    endfunction

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);
    assign r_exp = re_reg;
    assign r_mant = rm_reg;
    assign r_err = rerr_reg;

    // Dividend bit i of (x << FRAC), from the top
    assign bit_pos = DIV_STEPS - CNT_W'(1) - cnt_reg;
    assign x_idx = bit_pos - CNT_W'(FRAC);
    always_comb
    begin
        if (bit_pos >= CNT_W'(FRAC))
            div_bit = x_reg[x_idx[$clog2(MANT_W)-1:0]];
        else
            div_bit = 1'b0;
    end
    assign rem_sh = {acc_reg[MANT_W-1:0], div_bit};
    assign sub_res = {1'b0, rem_sh} - {2'b00, y_reg};
    assign sub_ok = !sub_res[MANT_W+1];

    always_comb
    begin
        logic a_err, b_err, a_zero, b_zero;
        logic signed [MANT_W-1:0] bm_eff;
        logic signed [EXP_W-1:0] ea, eb;
        logic signed [MANT_W-1:0] ma, mb;
        logic signed [DIFF_W-1:0] diff;
        logic signed [MANT_W-1:0] shv;
        logic signed [MANT_W:0] sum;
        logic signed [EXP_W+1:0] esum;
        logic [MANT_W-1:0] q;
        logic [2*MANT_W:0] psum;

        state_next = state_reg;
        e_next = e_reg;
        neg_next = neg_reg;
        v_next = v_reg;
        x_next = x_reg;
        y_next = y_reg;
        acc_next = acc_reg;
        over_next = over_reg;
        cnt_next = cnt_reg;
        re_next = re_reg;
        rm_next = rm_reg;
        rerr_next = rerr_reg;
        zpass_next = zpass_reg;
        am_next = am_reg;
        bm_next = bm_reg;
        ae_next = ae_reg;
        be_next = be_reg;
        a_err = 1'b0; b_err = 1'b0; a_zero = 1'b0; b_zero = 1'b0;
        bm_eff = '0; ea = '0; eb = '0; ma = '0; mb = '0; diff = '0;
        shv = '0; sum = '0; esum = '0; q = '0; psum = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    a_err = (a_exp == EXP_ERR) || (a_mant == M_ERR);
                    b_err = (b_exp == EXP_ERR) || (b_mant == M_ERR);
                    a_zero = (a_exp == '0) && (a_mant == '0);
                    b_zero = (b_exp == '0) && (b_mant == '0);
                    ae_next = a_exp; am_next = a_mant;
                    be_next = b_exp; bm_next = b_mant;
                    x_next = mag(a_mant);
                    y_next = mag(b_mant);
                    neg_next = a_mant[MANT_W-1] ^ b_mant[MANT_W-1];
                    acc_next = '0;
                    over_next = 1'b0;
                    cnt_next = '0;
                    zpass_next = 1'b0;
                    state_next = ST_DONE;
                    re_next = EXP_ERR; rm_next = M_ERR; rerr_next = 1'b1;
                    priority case (req_type)
                        OP_NEG:
                        begin
                            if (a_err)
                            begin
                                re_next = a_exp; rm_next = a_mant;
                            end
                            else if (a_zero)
                            begin
                                re_next = '0; rm_next = '0; rerr_next = 1'b0;
                            end
                            else if (a_mant == -$signed(M_MAX))
                            begin
                                re_next = EXP_ERR;
                            end
                            else
                            begin
                                re_next = a_exp; rm_next = -a_mant; rerr_next = 1'b0;
                            end
                        end
                        OP_ADD, OP_SUB:
                        begin
                            // effective b after optional negate
                            if (req_type == OP_SUB)
                            begin
                                if (b_err)
                                    b_err = 1'b1;
                                else if (b_zero)
                                    bm_next = '0;
                                else if (b_mant == -$signed(M_MAX))
                                    b_err = 1'b1;
                                else
                                    bm_next = -b_mant;
                            end
                            if (a_err || b_err)
                                state_next = ST_DONE;
                            else
                                state_next = ST_ALIGN;
                        end
                        OP_MUL:
                        begin
                            esum = (EXP_W+2)'(a_exp) + (EXP_W+2)'(b_exp);
                            e_next = esum;
                            if (a_err || b_err)
                                state_next = ST_DONE;
                            else if (a_zero || b_zero)
                            begin
                                re_next = '0; rm_next = '0; rerr_next = 1'b0;
                            end
                            else if (esum > (EXP_W+2)'(EXP_LIM) ||
                                     esum < -(EXP_W+2)'(EXP_LIM))
                                state_next = ST_DONE;
                            else
                                state_next = ST_MUL;
                        end
                        OP_DIV:
                        begin
                            esum = (EXP_W+2)'(a_exp) - (EXP_W+2)'(b_exp);
                            e_next = esum;
                            if (a_err || b_err || b_mant == '0)
                                state_next = ST_DONE;
                            else if (a_zero)
                            begin
                                re_next = '0; rm_next = '0; rerr_next = 1'b0;
                            end
                            else if (esum > (EXP_W+2)'(EXP_LIM) ||
                                     esum < -(EXP_W+2)'(EXP_LIM))
                                state_next = ST_DONE;
                            else
                                state_next = ST_DIV;
                        end
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_ALIGN:
            begin
                a_zero = (ae_reg == '0) && (am_reg == '0);
                b_zero = (be_reg == '0) && (bm_reg == '0);
                if (a_zero)
                begin
                    re_next = be_reg; rm_next = bm_reg; rerr_next = 1'b0;
                    state_next = ST_DONE;
                end
                else if (b_zero)
                begin
                    re_next = ae_reg; rm_next = am_reg; rerr_next = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    if (ae_reg < be_reg)
                    begin
                        ea = be_reg; ma = bm_reg; eb = ae_reg; mb = am_reg;
                    end
                    else
                    begin
                        ea = ae_reg; ma = am_reg; eb = be_reg; mb = bm_reg;
                    end
                    diff = DIFF_W'(ea) - DIFF_W'(eb);
                    if (diff >= DIFF_W'(MANT_W))
                        shv = mb[MANT_W-1] ? '1 : '0;
                    else
                        shv = mb >>> diff[$clog2(MANT_W)-1:0];
                    // gap of MANT_W or more gives plain zero
                    if (diff >= DIFF_W'(MANT_W))
                        shv = '0;
                    sum = (MANT_W+1)'(ma) + (MANT_W+1)'(shv);
                    if (sum > $signed({1'b0, M_MAX}) || sum < -$signed({1'b0, M_MAX}))
                        state_next = ST_DONE;
                    else
                    begin
                        e_next = (EXP_W+2)'(ea);
                        neg_next = sum[MANT_W];
                        v_next = sum[MANT_W] ? (MANT_W+1)'(-sum) : (MANT_W+1)'(sum);
                        zpass_next = (ea == '0) && (sum == '0);
                        state_next = ST_NORM;
                    end
                end
            end
            ST_MUL:
            begin
                // shift-add, one multiplier bit per cycle, LSB first
                acc_next = {1'b0, acc_reg[2*MANT_W-1:1]};
                if (y_reg[cnt_reg[$clog2(MANT_W)-1:0]])
                begin
                    psum = {1'b0, acc_reg} + {1'b0, x_reg, {MANT_W{1'b0}}};
                    acc_next = psum[2*MANT_W:1];
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == MUL_STEPS - CNT_W'(1))
                begin
                    if (acc_next >> (MANT_W + FRAC) != '0)
                        state_next = ST_DONE;
                    else
                    begin
                        q = acc_next[FRAC +: MANT_W];
                        if (q > M_MAX)
                            state_next = ST_DONE;
                        else
                        begin
                            v_next = {1'b0, q};
                            state_next = ST_NORM;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                q = x_next;
                if (sub_ok)
                begin
                    acc_next = {{MANT_W{1'b0}}, sub_res[MANT_W-1:0]};
                    if (bit_pos >= CNT_W'(MANT_W - 1))
                        over_next = 1'b1;
                    else
                        v_next = v_reg | ((MANT_W+1)'(1) << bit_pos);
                end
                else
                    acc_next = {{(MANT_W-1){1'b0}}, rem_sh};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == DIV_STEPS - CNT_W'(1))
                begin
                    if (over_next || v_next > {1'b0, M_MAX})
                        state_next = ST_DONE;
                    else
                        state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                // one left shift per cycle until the leading bit lands or the exponent floor is reached
                if (zpass_reg)
                begin
                    re_next = '0; rm_next = '0; rerr_next = 1'b0;
                    state_next = ST_DONE;
                end
                else if (v_reg != '0 && !v_reg[FRAC] && e_reg > -(EXP_W+2)'(EXP_FLOOR))
                begin
                    v_next = v_reg << 1;
                    e_next = e_reg - (EXP_W+2)'(1);
                end
                else
                begin
                    if (e_reg < -(EXP_W+2)'(EXP_FLOOR))
                    begin
                        re_next = '0; rm_next = '0;
                    end
                    else
                    begin
                        re_next = EXP_W'(e_reg);
                        rm_next = neg_reg ? -$signed(v_reg[MANT_W-1:0])
                                          : $signed(v_reg[MANT_W-1:0]);
                    end
                    rerr_next = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
        if (state_reg == ST_IDLE && start && (req_type == OP_MUL || req_type == OP_DIV))
            v_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        e_reg <= e_next;
        neg_reg <= neg_next;
        v_reg <= v_next;
        x_reg <= x_next;
        y_reg <= y_next;
        acc_reg <= acc_next;
        over_reg <= over_next;
        cnt_reg <= cnt_next;
        re_reg <= re_next;
        rm_reg <= rm_next;
        rerr_reg <= rerr_next;
        zpass_reg <= zpass_next;
        am_reg <= am_next;
        bm_reg <= bm_next;
        ae_reg <= ae_next;
        be_reg <= be_next;
    end

endmodule

// ===== rtl/sentinel_float_arith_unit.sv =====
// Sequential sentinel float unit. Raise start with an opcode and operands while busy
// is low; the single result appears for one cycle with done high and cannot be stalled.
// Negate, error and mul/div zero cases go straight to DONE; add/sub pass ALIGN and,
// unless an operand is zero, NORM; mul steps a shift-add adder one multiplier bit at
// a time and div a restoring subtractor one quotient bit at a time, each then
// normalizing by left shifts in NORM.
module sentinel_float_arith_unit #(
    parameter int MANT_W = 48
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         req_type,
    input  logic signed [15:0] a_exp,
    input  logic signed [47:0] a_mant,
    input  logic signed [15:0] b_exp,
    input  logic signed [47:0] b_mant,
    output logic               done,
    output logic signed [15:0] r_exp,
    output logic signed [47:0] r_mant,
    output logic               r_err
);
    import sfau_pkg::*;

    logic signed [MANT_W-1:0] rm;

    sfau_core #(.MANT_W(MANT_W)) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .a_exp    (a_exp),
        .a_mant   (a_mant[MANT_W-1:0]),
        .b_exp    (b_exp),
        .b_mant   (b_mant[MANT_W-1:0]),
        .busy     (busy),
        .done     (done),
        .r_exp    (r_exp),
        .r_mant   (rm),
        .r_err    (r_err)
    );

    assign r_mant = OUT_MANT_W'(rm);

    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held two cycles");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done while idle");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start not taken");

endmodule
